FILE: hw/rtl/piecewise_linear_table_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define PLTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PLTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 8;
    localparam int DIFF_W      = VALUE_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = VALUE_WIDTH + 2;

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_QUERY  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDEF   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POS_BELOW  = 2'd0,
        POS_INSIDE = 2'd1,
        POS_ABOVE  = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        MODE_UNDEF  = 2'd0,
        MODE_ZERO   = 2'd1,
        MODE_END    = 2'd2,
        MODE_EXTRAP = 2'd3
    } t_mode;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/plti_ram.sv
// ----------------------------------------------------------------------------
// plti_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/plti_div.sv
// ----------------------------------------------------------------------------
// plti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_div
    import plti_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_numer,
    input  wire logic [DIFF_W-1:0] i_denom,
    output t_div_rsp               o_rsp
);

    localparam int CW = $clog2(PROD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIFF_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [DIFF_W-1:0] r_den, n_den;
    logic [DIFF_W:0]   rem_sh;
    logic [DIFF_W:0]   diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_acc  = r_acc;
        n_den  = r_den;
        rem_sh = {r_rem, r_acc[PROD_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(PROD_W);
            n_rem  = '0;
            n_acc  = i_numer;
            n_den  = i_denom;
        end else if (r_busy) begin
            n_rem = diff[DIFF_W] ? rem_sh[DIFF_W-1:0] : diff[DIFF_W-1:0];
            n_acc = {r_acc[PROD_W-2:0], ~diff[DIFF_W]};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/piecewise_linear_table_interpolator.sv
// Piecewise linear table interpolator. Breakpoints are loaded with clear and
// append transactions into two 256-entry RAMs (x and y), one read port each.
// Clear, append, unused codes and queries on an invalid table go straight to
// the result state. A query reads the last and first breakpoints, then runs
// a binary search of up to eight RAM reads, one per cycle; outside the table
// without extrapolation it finishes there. An interpolating query then reads
// both interval ends, multiplies, and runs a 66-step serial divider unless
// the interval has zero width. One transaction is in work at a time; a
// finished result sits in the output register while the next transaction is
// taken.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Top level: breakpoint memories, search sequencer and result arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_table_interpolator_macros.svh"

module piecewise_linear_table_interpolator
    import plti_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [1:0]             i_cfg_wr_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_func,
    input  wire logic [VALUE_WIDTH-1:0] i_x_value,
    input  wire logic [VALUE_WIDTH-1:0] i_y_value,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [VALUE_WIDTH-1:0]      o_y_result,
    output logic [IDX_W-1:0]            o_interval_index,
    output logic [1:0]                  o_position,
    output logic [1:0]                  o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_FIRST, S_SEARCH, S_RD0, S_RD1, S_MUL, S_DIV, S_FIN, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_order, n_order;
    logic             r_out_valid, n_out_valid;

    logic signed [VALUE_WIDTH-1:0] r_last_x, n_last_x;
    logic signed [VALUE_WIDTH-1:0] r_xq, n_xq;
    logic signed [VALUE_WIDTH-1:0] r_xlast, n_xlast;
    logic signed [VALUE_WIDTH-1:0] r_ylast, n_ylast;
    logic signed [VALUE_WIDTH-1:0] r_x0, n_x0;
    logic signed [VALUE_WIDTH-1:0] r_y0, n_y0;
    logic signed [DIFF_W-1:0]      r_dx, n_dx;
    logic [DIFF_W-1:0]             r_num_mag, n_num_mag;
    logic [DIFF_W-1:0]             r_dy_mag, n_dy_mag;
    logic                          r_neg, n_neg;
    logic                          r_interp, n_interp;
    logic [ADDR_W-1:0]             r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;

    logic [VALUE_WIDTH-1:0] r_res_y, n_res_y;
    logic [ADDR_W-1:0]      r_res_idx, n_res_idx;
    t_pos                   r_res_pos, n_res_pos;
    t_status                r_res_st, n_res_st;

    logic [VALUE_WIDTH-1:0] r_o_y, n_o_y;
    logic [ADDR_W-1:0]      r_o_idx, n_o_idx;
    t_pos                   r_o_pos, n_o_pos;
    t_status                r_o_st, n_o_st;

    logic                   wr_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] x_rd, y_rd;
    logic                   div_start;
    t_div_rsp               div_rsp;
    logic [PROD_W-1:0]      prod_c;

    logic signed [DIFF_W-1:0] dx_c, dy_c, num_c;
    logic [ADDR_W:0]          mid_sum;
    logic                     go_right;
    logic [DIFF_W-1:0]        q_c;
    logic signed [SUM_W-1:0]  sum_c;
    t_pos                     pos_c;
    logic                     order_c;

    localparam logic [DIFF_W-1:0] QLIM = {1'b1, {VALUE_WIDTH{1'b0}}};
    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

    plti_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(VALUE_WIDTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_x_value),
        .i_raddr (rd_addr),
        .o_rdata (x_rd)
    );

    plti_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(VALUE_WIDTH)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_y_value),
        .i_raddr (rd_addr),
        .o_rdata (y_rd)
    );

    assign prod_c = PROD_W'(r_num_mag) * PROD_W'(r_dy_mag);

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (prod_c),
        .i_denom (r_dx),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_order     = r_order;
        n_out_valid = r_out_valid && i_out_stall;
        n_last_x    = r_last_x;
        n_xq        = r_xq;
        n_xlast     = r_xlast;
        n_ylast     = r_ylast;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_dx        = r_dx;
        n_num_mag   = r_num_mag;
        n_dy_mag    = r_dy_mag;
        n_neg       = r_neg;
        n_interp    = r_interp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res_y     = r_res_y;
        n_res_idx   = r_res_idx;
        n_res_pos   = r_res_pos;
        n_res_st    = r_res_st;
        n_o_y       = r_o_y;
        n_o_idx     = r_o_idx;
        n_o_pos     = r_o_pos;
        n_o_st      = r_o_st;
        wr_en       = 1'b0;
        rd_addr     = r_mid;
        div_start   = 1'b0;
        order_c     = r_order;
        pos_c       = POS_INSIDE;

        dx_c     = DIFF_W'($signed(x_rd)) - DIFF_W'(r_x0);
        dy_c     = DIFF_W'($signed(y_rd)) - DIFF_W'(r_y0);
        num_c    = DIFF_W'(r_xq) - DIFF_W'(r_x0);
        go_right = ($signed(x_rd) <= r_xq) && ($signed(x_rd) < r_xlast);
        mid_sum  = '0;
        q_c      = (div_rsp.quot[PROD_W-1:DIFF_W] != '0 ||
                    div_rsp.quot[DIFF_W-1:0] > QLIM) ? QLIM : div_rsp.quot[DIFF_W-1:0];
        sum_c    = r_neg ? SUM_W'(r_y0) - SUM_W'(q_c) : SUM_W'(r_y0) + SUM_W'(q_c);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_y   = '0;
                    n_res_idx = '0;
                    n_res_pos = POS_BELOW;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                    case (t_func'(i_func))
                        FN_CLEAR: begin
                            n_count = '0;
                            n_order = 1'b1;
                        end
                        FN_APPEND: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res_st = ST_FULL;
                            end else begin
                                order_c = r_order &&
                                    !(r_count != '0 && $signed(i_x_value) < r_last_x);
                                wr_en    = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_order  = order_c;
                                n_last_x = $signed(i_x_value);
                                n_res_st = order_c ? ST_OK : ST_INVALID;
                            end
                        end
                        FN_QUERY: begin
                            if (r_count < CNT_W'(2) || !r_order) begin
                                n_res_st = ST_INVALID;
                            end else begin
                                n_xq    = $signed(i_x_value);
                                n_hi    = ADDR_W'(r_count - CNT_W'(1));
                                rd_addr = ADDR_W'(r_count - CNT_W'(1));
                                n_state = S_LAST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LAST: begin
                n_xlast = $signed(x_rd);
                n_ylast = $signed(y_rd);
                rd_addr = '0;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                if (r_xq < $signed(x_rd)) begin
                    pos_c = POS_BELOW;
                end else if (r_xq > r_xlast) begin
                    pos_c = POS_ABOVE;
                end
                n_res_pos = pos_c;
                n_interp  = (pos_c == POS_INSIDE) || (r_mode == MODE_EXTRAP);
                if (pos_c != POS_INSIDE) begin
                    case (r_mode)
                        MODE_UNDEF: n_res_st = ST_UNDEF;
                        MODE_END:   n_res_y  = (pos_c == POS_BELOW) ? y_rd : r_ylast;
                        default: begin
                        end
                    endcase
                end
                n_lo    = '0;
                n_mid   = r_hi >> 1;
                rd_addr = r_hi >> 1;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_lo = go_right ? r_mid + ADDR_W'(1) : r_lo;
                n_hi = go_right ? r_hi : r_mid;
                mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
                if (n_lo < n_hi) begin
                    n_mid   = mid_sum[ADDR_W:1];
                    rd_addr = mid_sum[ADDR_W:1];
                end else begin
                    n_res_idx = (n_lo == '0) ? '0 : n_lo - ADDR_W'(1);
                    rd_addr   = n_res_idx;
                    n_state   = r_interp ? S_RD0 : S_DONE;
                end
            end
            S_RD0: begin
                n_x0    = $signed(x_rd);
                n_y0    = $signed(y_rd);
                rd_addr = r_res_idx + ADDR_W'(1);
                n_state = S_RD1;
            end
            S_RD1: begin
                n_dx      = dx_c;
                n_num_mag = num_c[DIFF_W-1] ? DIFF_W'(-num_c) : DIFF_W'(num_c);
                n_dy_mag  = dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
                n_neg     = num_c[DIFF_W-1] ^ dy_c[DIFF_W-1];
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (r_dx <= 0) begin
                    n_res_y = r_y0;
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (sum_c > VMAX) begin
                    n_res_y = VMAX[VALUE_WIDTH-1:0];
                end else if (sum_c < VMIN) begin
                    n_res_y = VMIN[VALUE_WIDTH-1:0];
                end else begin
                    n_res_y = sum_c[VALUE_WIDTH-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_y       = r_res_y;
                    n_o_idx     = r_res_idx;
                    n_o_pos     = r_res_pos;
                    n_o_st      = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_order     <= 1'b1;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_UNDEF;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_order     <= n_order;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_mode <= t_mode'(i_cfg_wr_data);
            end
        end
        r_last_x  <= n_last_x;
        r_xq      <= n_xq;
        r_xlast   <= n_xlast;
        r_ylast   <= n_ylast;
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_dx      <= n_dx;
        r_num_mag <= n_num_mag;
        r_dy_mag  <= n_dy_mag;
        r_neg     <= n_neg;
        r_interp  <= n_interp;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res_y   <= n_res_y;
        r_res_idx <= n_res_idx;
        r_res_pos <= n_res_pos;
        r_res_st  <= n_res_st;
        r_o_y     <= n_o_y;
        r_o_idx   <= n_o_idx;
        r_o_pos   <= n_o_pos;
        r_o_st    <= n_o_st;
    end

    assign o_out_valid      = r_out_valid;
    assign o_y_result       = r_o_y;
    assign o_interval_index = IDX_W'(r_o_idx);
    assign o_position       = r_o_pos;
    assign o_status         = r_o_st;

    `PLTI_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_DEPTH))
    `PLTI_ASSERT_NOW(a_search_open, i_clk, i_rst_n, r_state == S_SEARCH, r_lo < r_hi)
    `PLTI_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV)
    `PLTI_ASSERT_NOW(a_bad_status_zero_y, i_clk, i_rst_n,
        o_out_valid && o_status != ST_OK, o_y_result == '0)

endmodule

`default_nettype wire
